@@ rtl/core/xyli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyli_pkg
// Shared types, command codes and constants of the XY step line interpolator.
// ----------------------------------------------------------------------------
package xyli_pkg;

  localparam int POS_BITS_DEF = 32;
  localparam int FIELD_W      = 32;
  localparam int RATE_W       = 16;
  localparam int CFG_ADDR_W   = 2;
  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 88;

  localparam logic [RATE_W-1:0]     RAPID_RATE_RST = 16'd1000;
  localparam logic [CFG_ADDR_W-1:0] REG_RAPID_RATE = 2'd0;

  // command codes carried on tuser
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_LINE   = 3'd1;
  localparam logic [2:0] ACT_JOG    = 3'd2;
  localparam logic [2:0] ACT_ORIGIN = 3'd3;
  localparam logic [2:0] ACT_HOLD   = 3'd4;
  localparam logic [2:0] ACT_REL    = 3'd5;
  localparam logic [2:0] ACT_STOP   = 3'd6;

  localparam logic [1:0] STEP_NONE  = 2'd0;
  localparam logic [1:0] STEP_PLUS  = 2'd1;
  localparam logic [1:0] STEP_MINUS = 2'd2;

  localparam logic [1:0] JOG_X_PLUS  = 2'd0;
  localparam logic [1:0] JOG_X_MINUS = 2'd1;
  localparam logic [1:0] JOG_Y_PLUS  = 2'd2;
  localparam logic [1:0] JOG_Y_MINUS = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic [FIELD_W-1:0] target_x;
    logic [FIELD_W-1:0] target_y;
    logic               rapid;
    logic [RATE_W-1:0]  feed;
    logic               tool_down;
    logic [1:0]         jog_dir;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         step_x;
    logic [1:0]         step_y;
    logic [FIELD_W-1:0] work_x;
    logic [FIELD_W-1:0] work_y;
    logic               busy_res;
    logic               done_now;
    logic               cutter_on;
    logic [RATE_W-1:0]  step_rate;
    logic               ignored;
  } res_t;

endpackage

@@ rtl/core/xyli_motion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyli_motion
// Position, line and mode state; applies one command per enabled cycle and
// presents the result of that command combinationally.
// ----------------------------------------------------------------------------
module xyli_motion import xyli_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  cmd_t              cmd,
  input  logic [RATE_W-1:0] rapid_rate,
  output res_t              res
);

  localparam int DW = POS_BITS + 1;
  localparam int EW = POS_BITS + 2;

  // Work position is kept directly: origin only ever shifts it.
  logic [POS_BITS-1:0] work_x_r, work_x_nxt, work_y_r, work_y_nxt;
  logic [POS_BITS-1:0] goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [DW-1:0]       delta_x_r, delta_x_nxt, delta_y_r, delta_y_nxt;
  logic [EW-1:0]       err_r, err_nxt;
  logic                dir_x_neg_r, dir_x_neg_nxt, dir_y_neg_r, dir_y_neg_nxt;
  logic                moving_r, moving_nxt, held_r, held_nxt;
  logic                running_r, running_nxt, cutter_r, cutter_nxt;
  logic [RATE_W-1:0]   move_rate_r, move_rate_nxt;

  logic [POS_BITS-1:0] line_gx, line_gy, tick_wx, tick_wy;
  logic [DW-1:0]       line_dx, line_dy, line_mx, line_my, tick_ex, tick_ey;
  logic                tick_on_x;
  logic [1:0]          sx, sy;
  logic [RATE_W-1:0]   rate;
  logic                done, ign;

  function automatic logic near1(input logic [DW-1:0] v);
    near1 = (v == '0) || (v == DW'(1)) || (v == '1);
  endfunction

  // begin line: offsets from the current work position
  assign line_gx = POS_BITS'($signed(cmd.target_x));
  assign line_gy = POS_BITS'($signed(cmd.target_y));
  assign line_dx = {line_gx[POS_BITS-1], line_gx} - {work_x_r[POS_BITS-1], work_x_r};
  assign line_dy = {line_gy[POS_BITS-1], line_gy} - {work_y_r[POS_BITS-1], work_y_r};
  assign line_mx = line_dx[DW-1] ? (~line_dx + DW'(1)) : line_dx;
  assign line_my = line_dy[DW-1] ? (~line_dy + DW'(1)) : line_dy;

  // tick: step X while the error term is positive
  assign tick_on_x = !err_r[EW-1] && (|err_r);
  always_comb begin
    tick_wx = work_x_r;
    tick_wy = work_y_r;
    if (tick_on_x) begin
      tick_wx = dir_x_neg_r ? (work_x_r - POS_BITS'(1)) : (work_x_r + POS_BITS'(1));
    end else begin
      tick_wy = dir_y_neg_r ? (work_y_r - POS_BITS'(1)) : (work_y_r + POS_BITS'(1));
    end
  end
  assign tick_ex = {goal_x_r[POS_BITS-1], goal_x_r} - {tick_wx[POS_BITS-1], tick_wx};
  assign tick_ey = {goal_y_r[POS_BITS-1], goal_y_r} - {tick_wy[POS_BITS-1], tick_wy};

  always_comb begin
    work_x_nxt    = work_x_r;
    work_y_nxt    = work_y_r;
    goal_x_nxt    = goal_x_r;
    goal_y_nxt    = goal_y_r;
    delta_x_nxt   = delta_x_r;
    delta_y_nxt   = delta_y_r;
    err_nxt       = err_r;
    dir_x_neg_nxt = dir_x_neg_r;
    dir_y_neg_nxt = dir_y_neg_r;
    moving_nxt    = moving_r;
    held_nxt      = held_r;
    running_nxt   = running_r;
    cutter_nxt    = cutter_r;
    move_rate_nxt = move_rate_r;
    sx            = STEP_NONE;
    sy            = STEP_NONE;
    rate          = '0;
    done          = 1'b0;
    ign           = 1'b0;
    case (cmd.action)
      ACT_TICK: begin
        if (moving_r && !held_r) begin
          work_x_nxt = tick_wx;
          work_y_nxt = tick_wy;
          if (tick_on_x) begin
            sx      = dir_x_neg_r ? STEP_MINUS : STEP_PLUS;
            err_nxt = err_r - {1'b0, delta_y_r};
          end else begin
            sy      = dir_y_neg_r ? STEP_MINUS : STEP_PLUS;
            err_nxt = err_r + {1'b0, delta_x_r};
          end
          rate = move_rate_r;
          if (near1(tick_ex) && near1(tick_ey)) begin
            work_x_nxt = goal_x_r;
            work_y_nxt = goal_y_r;
            moving_nxt = 1'b0;
            done       = 1'b1;
          end
        end
      end
      ACT_LINE: begin
        goal_x_nxt    = line_gx;
        goal_y_nxt    = line_gy;
        dir_x_neg_nxt = line_dx[DW-1];
        dir_y_neg_nxt = line_dy[DW-1];
        delta_x_nxt   = line_mx;
        delta_y_nxt   = line_my;
        err_nxt       = {1'b0, line_mx} - {1'b0, line_my};
        cutter_nxt    = cmd.tool_down;
        move_rate_nxt = cmd.rapid ? rapid_rate : cmd.feed;
        moving_nxt    = 1'b1;
        if (near1(line_dx) && near1(line_dy)) begin
          work_x_nxt = line_gx;
          work_y_nxt = line_gy;
          moving_nxt = 1'b0;
          done       = 1'b1;
        end
      end
      ACT_JOG: begin
        if (running_r) begin
          ign = 1'b1;
        end else begin
          rate = rapid_rate;
          case (cmd.jog_dir)
            JOG_X_PLUS: begin
              work_x_nxt = work_x_r + POS_BITS'(1);
              sx         = STEP_PLUS;
            end
            JOG_X_MINUS: begin
              work_x_nxt = work_x_r - POS_BITS'(1);
              sx         = STEP_MINUS;
            end
            JOG_Y_PLUS: begin
              work_y_nxt = work_y_r + POS_BITS'(1);
              sy         = STEP_PLUS;
            end
            default: begin
              work_y_nxt = work_y_r - POS_BITS'(1);
              sy         = STEP_MINUS;
            end
          endcase
        end
      end
      ACT_ORIGIN: begin
        if (running_r) begin
          ign = 1'b1;
        end else begin
          work_x_nxt = '0;
          work_y_nxt = '0;
        end
      end
      ACT_HOLD: begin
        held_nxt = 1'b1;
      end
      ACT_REL: begin
        held_nxt    = 1'b0;
        running_nxt = 1'b1;
      end
      ACT_STOP: begin
        running_nxt = 1'b0;
        moving_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.step_x    = sx;
    res.step_y    = sy;
    res.work_x    = FIELD_W'($signed(work_x_nxt));
    res.work_y    = FIELD_W'($signed(work_y_nxt));
    res.busy_res  = moving_nxt;
    res.done_now  = done;
    res.cutter_on = cutter_nxt;
    res.step_rate = rate;
    res.ignored   = ign;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_x_r    <= '0;
      work_y_r    <= '0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      delta_x_r   <= '0;
      delta_y_r   <= '0;
      err_r       <= '0;
      dir_x_neg_r <= 1'b0;
      dir_y_neg_r <= 1'b0;
      moving_r    <= 1'b0;
      held_r      <= 1'b1;
      running_r   <= 1'b0;
      cutter_r    <= 1'b0;
      move_rate_r <= '0;
    end else if (en) begin
      work_x_r    <= work_x_nxt;
      work_y_r    <= work_y_nxt;
      goal_x_r    <= goal_x_nxt;
      goal_y_r    <= goal_y_nxt;
      delta_x_r   <= delta_x_nxt;
      delta_y_r   <= delta_y_nxt;
      err_r       <= err_nxt;
      dir_x_neg_r <= dir_x_neg_nxt;
      dir_y_neg_r <= dir_y_neg_nxt;
      moving_r    <= moving_nxt;
      held_r      <= held_nxt;
      running_r   <= running_nxt;
      cutter_r    <= cutter_nxt;
      move_rate_r <= move_rate_nxt;
    end
  end

endmodule

@@ rtl/core/xy_step_line_interpolator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xy_step_line_interpolator_core
// Two-axis stepper line interpolator with work origin, jog and run control.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer; in_tuser carries the action code,
//           in_tdata the targets, rate, tool and jog fields.
//   out_* : one result per command: step codes, work position after the
//           command, move status, cutter level, reported rate, refusal.
//   cfg_* : register port holding rapid_rate (byte address 0).
// Path: an accepted command is registered in the input register; when the
//   stage fires it is applied and its result is registered onto out_*.
// Throughput: one command per clock unless stalled; a tick is one step add
//   plus a goal-distance compare, a line start is a subtract, an absolute
//   value and an error-term subtract, all within the single compute stage.
// Reset: position and origin go to zero, no move is active, the block is
//   held and not running, rapid_rate returns to 1000.
// Stall: while out_tready is low the result stays and one more command
//   is taken into the input register; then in_tready drops.
// ----------------------------------------------------------------------------
module xy_step_line_interpolator_core import xyli_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: target_x[31:0], target_y[63:32], rapid[64], feed[80:65],
  //           tool_down[81], jog_dir[83:82], zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: action[2:0]
  input  logic [2:0]            in_tuser,
  // out_tdata: step_x[1:0], step_y[3:2], work_x[35:4], work_y[67:36],
  //            busy_res[68], done_now[69], cutter_on[70], step_rate[86:71],
  //            ignored[87]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic              in_valid_r, in_valid_nxt;
  cmd_t              cmd_r, cmd_in;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_c;
  logic [RATE_W-1:0] rapid_rate_r;
  logic              in_fire, stg_fire, cfg_wr;

  assign cmd_in.action    = in_tuser;
  assign cmd_in.target_x  = in_tdata[31:0];
  assign cmd_in.target_y  = in_tdata[63:32];
  assign cmd_in.rapid     = in_tdata[64];
  assign cmd_in.feed      = in_tdata[80:65];
  assign cmd_in.tool_down = in_tdata[81];
  assign cmd_in.jog_dir   = in_tdata[83:82];

  assign stg_fire  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || stg_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (stg_fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (stg_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_in;
    end
    if (stg_fire) begin
      res_r <= res_c;
    end
  end

  xyli_motion #(
    .POS_BITS(POS_BITS)
  ) u_motion (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stg_fire),
    .cmd       (cmd_r),
    .rapid_rate(rapid_rate_r),
    .res       (res_c)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.ignored, res_r.step_rate, res_r.cutter_on, res_r.done_now,
                       res_r.busy_res, res_r.work_y, res_r.work_x, res_r.step_y,
                       res_r.step_x};

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_RAPID_RATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rapid_rate_r <= RAPID_RATE_RST;
    end else if (cfg_wr) begin
      rapid_rate_r <= cfg_pwdata[RATE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == REG_RAPID_RATE) ? {16'd0, rapid_rate_r} : '0;

`ifndef SYNTHESIS
  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((res_r.step_x != STEP_NONE) && (res_r.step_y != STEP_NONE)))
    else $error("both axes stepped on one command");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done_now) |-> !res_r.busy_res)
    else $error("move reported done while still busy");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.ignored) |->
      (res_r.step_x == STEP_NONE && res_r.step_y == STEP_NONE && res_r.step_rate == '0))
    else $error("refused command produced a step");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |=> in_valid_r && $stable(cmd_r))
    else $error("pending command lost during output stall");
`endif

endmodule
